// ===== design/ppu_pkg.sv =====
package ppu_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned FracW  = 17;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned RandW  = 7;
  localparam int unsigned CmdW   = 2;

  localparam logic [CmdW-1:0] CmdSpawn   = 2'd0;
  localparam logic [CmdW-1:0] CmdTick    = 2'd1;
  localparam logic [CmdW-1:0] CmdRead    = 2'd2;
  localparam logic [CmdW-1:0] CmdUnknown = 2'd3;

  localparam logic [FracW-1:0] OneQ16 = 17'd65536;
  localparam logic signed [PosW-1:0] PosMax = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] PosMin = -24'sh800000;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StTick,
    StCount,
    StDone
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic signed [PosW-1:0]   ball_x;
    logic signed [PosW-1:0]   ball_y;
    logic signed [PosW-1:0]   ball_vel_x;
    logic signed [PosW-1:0]   ball_vel_y;
    logic signed [PosW-1:0]   spawn_offset_x;
    logic signed [PosW-1:0]   spawn_offset_y;
    logic [RandW-1:0]         jitter_random;
    logic [RandW-1:0]         shade_random;
    logic [DeltaW-1:0]        delta_time;
    logic [SlotW-1:0]         read_slot;
  } in_word_t;

  typedef struct packed {
    logic [SlotW-1:0]         slot_index;
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic [FracW-1:0]         brightness;
    logic [FracW-1:0]         alpha;
    logic [FracW-1:0]         life_left;
    logic [CountW-1:0]        live_count;
  } out_word_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] vel_x;
    logic signed [PosW-1:0] vel_y;
    logic [FracW-1:0]       shade;
    logic [FracW-1:0]       alpha;
    logic [FracW-1:0]       life;
  } slot_t;

  function automatic logic signed [PosW-1:0] sat24(input logic signed [PosW+1:0] x);
    if (x > $signed({2'b00, PosMax})) begin
      return PosMax;
    end else if (x < $signed({2'b11, PosMin})) begin
      return PosMin;
    end
    return x[PosW-1:0];
  endfunction

  // Divide by ten, rounded to nearest with ties away from zero.
  function automatic logic signed [PosW-1:0] div10_round(input logic signed [PosW-1:0] v);
    logic [PosW:0]    mag;
    logic [PosW+25:0] prod;
    logic [PosW-1:0]  q;
    mag  = v[PosW-1] ? (PosW+1)'(-$signed({v[PosW-1], v})) : {1'b0, v};
    mag  = mag + (PosW+1)'(5);
    prod = (PosW+26)'(mag) * (PosW+26)'(26'd6710887);
    q    = prod[PosW+25:26];
    return v[PosW-1] ? PosW'(-$signed(q)) : q;
  endfunction

endpackage

// ===== design/ppu_if.sv =====
interface ppu_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ppu_slot_alu.sv =====
module ppu_slot_alu (
  input  ppu_pkg::slot_t                 slot_i,
  input  logic [ppu_pkg::DeltaW-1:0]     delta_i,
  output ppu_pkg::slot_t                 slot_o
);
  import ppu_pkg::*;

  logic [FracW-1:0]          life_n;
  logic [FracW+1:0]          fade;
  logic signed [47:0]        px;
  logic signed [47:0]        py;
  logic signed [PosW+1:0]    dx;
  logic signed [PosW+1:0]    dy;

  always_comb begin
    slot_o = slot_i;
    life_n = (slot_i.life > FracW'(delta_i)) ? slot_i.life - FracW'(delta_i) : '0;
    fade   = (19'(delta_i) * 19'd5 + 19'd1) >> 1;
    px     = 48'(slot_i.vel_x) * $signed({1'b0, delta_i}) + 48'sd32768;
    py     = 48'(slot_i.vel_y) * $signed({1'b0, delta_i}) + 48'sd32768;
    dx     = $signed({slot_i.pos_x[PosW-1], slot_i.pos_x[PosW-1], slot_i.pos_x})
             - px[PosW+17:16];
    dy     = $signed({slot_i.pos_y[PosW-1], slot_i.pos_y[PosW-1], slot_i.pos_y})
             - py[PosW+17:16];
    slot_o.life = life_n;
    if (life_n != '0) begin
      slot_o.pos_x = sat24(dx);
      slot_o.pos_y = sat24(dy);
      slot_o.alpha = ({2'b0, slot_i.alpha} > fade) ? slot_i.alpha - fade[FracW-1:0] : '0;
    end
  end
endmodule

// ===== design/particle_pool_update.sv =====
// A read or an unknown command makes one counting pass over the slots, a tick makes an
// update pass and then a counting pass, and a spawn probes slots from the last used one
// up to a free one before its counting pass. Each pass reads one slot per cycle.
// No new word is taken while busy, and a result that is not taken holds
// the block until it is.
// Reset clears the slot valid bits, the last used slot and the control at once.
module particle_pool_update #(
  parameter int unsigned PARTICLES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppu_if.sink   in_i,
  ppu_if.source out_o
);
  import ppu_pkg::*;

  localparam int unsigned IdxW = SlotW + 1;

  slot_t             mem_q [PARTICLES];
  logic [PARTICLES-1:0] vld_q;
  state_e            state_q, state_d;
  in_word_t          cmd_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic [SlotW-1:0]  last_q;
  logic [SlotW-1:0]  found_q, found_d;
  logic [CountW-1:0] live_q, live_d;
  slot_t             sel_q, sel_d;
  out_word_t         res_q, res_d;
  logic              ovalid_q;
  slot_t             rd_q;
  logic              rv_q;
  logic              pv_q;
  logic              pl_q;
  logic [SlotW-1:0]  pa_q;
  slot_t             rd_slot;
  slot_t             upd_slot;
  slot_t             new_slot;
  slot_t             new_q;
  logic [SlotW-1:0]  cur;
  logic              issue;
  logic              we;
  logic              load;
  logic [SlotW-1:0]  waddr;
  slot_t             wdata;
  logic signed [PosW+1:0] jit;
  logic [FracW-1:0]  shade;

  assign cur     = idx_q[SlotW-1:0];
  assign rd_slot = rv_q ? rd_q : '0;

  ppu_slot_alu u_alu (
    .slot_i (rd_slot),
    .delta_i(cmd_q.delta_time),
    .slot_o (upd_slot)
  );

  always_comb begin
    logic signed [15:0] jv;
    logic [15:0] jm;
    logic [31:0] jp;
    logic [11:0] jq;
    logic [12:0] sy;
    logic [26:0] sp;
    logic [6:0]  sq;
    jv = (16'(cmd_q.jitter_random) - 16'sd50) * 16'sd256;
    jm = jv[15] ? 16'(-jv) : jv;
    jp = 32'(jm + 16'd5) * 32'd104858;
    jq = jp[31:20];
    jit = jv[15] ? -(PosW+2)'(jq) : (PosW+2)'(jq);
    sy = 13'(13'(cmd_q.shade_random) * 13'd36 + 13'd50);
    sp = 27'(sy) * 27'd10486;
    sq = sp[26:20];
    shade = FracW'(17'd32768 + 17'(cmd_q.shade_random) * 17'd655 + 17'(sq));
    new_slot.pos_x = sat24(26'(cmd_q.ball_x) + 26'(cmd_q.spawn_offset_x) + jit);
    new_slot.pos_y = sat24(26'(cmd_q.ball_y) + 26'(cmd_q.spawn_offset_y) + jit);
    new_slot.vel_x = div10_round(cmd_q.ball_vel_x);
    new_slot.vel_y = div10_round(cmd_q.ball_vel_y);
    new_slot.shade = shade;
    new_slot.alpha = OneQ16;
    new_slot.life  = OneQ16;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    live_d  = live_q;
    sel_d   = sel_q;
    issue   = 1'b0;
    we      = 1'b0;
    waddr   = pa_q;
    wdata   = upd_slot;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          cnt_d   = '0;
          live_d  = '0;
          found_d = '0;
          sel_d   = '0;
          idx_d   = '0;
          unique case (in_i.data.command)
            CmdSpawn: begin
              idx_d = {1'b0, last_q};
              state_d = StSearch;
            end
            CmdTick: begin
              state_d = StTick;
            end
            default: begin
              state_d = StCount;
            end
          endcase
        end
      end
      StSearch: begin
        if (pv_q && (rd_slot.life == '0 || pl_q)) begin
          we      = 1'b1;
          waddr   = (rd_slot.life == '0) ? pa_q : '0;
          wdata   = new_q;
          found_d = waddr;
          idx_d   = '0;
          cnt_d   = '0;
          state_d = StCount;
        end else if (cnt_q < IdxW'(PARTICLES)) begin
          issue = 1'b1;
          cnt_d = cnt_q + 1'b1;
          idx_d = (idx_q == IdxW'(PARTICLES - 1)) ? '0 : idx_q + 1'b1;
        end
      end
      StTick: begin
        we = pv_q;
        if (pv_q && pl_q) begin
          idx_d   = '0;
          cnt_d   = '0;
          state_d = StCount;
        end else if (cnt_q < IdxW'(PARTICLES)) begin
          issue = 1'b1;
          cnt_d = cnt_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      StCount: begin
        if (pv_q) begin
          if (rd_slot.life != '0) begin
            live_d = live_q + 1'b1;
          end
          if (cmd_q.command == CmdRead && pa_q == cmd_q.read_slot) begin
            sel_d = rd_slot;
          end
        end
        if (pv_q && pl_q) begin
          idx_d   = '0;
          state_d = StDone;
        end else if (cnt_q < IdxW'(PARTICLES)) begin
          issue = 1'b1;
          cnt_d = cnt_q + 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      StDone: begin
        if (!ovalid_q || out_o.ready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign load = (state_q == StDone) && (state_d == StIdle);

  always_comb begin
    res_d = '0;
    res_d.live_count = live_q;
    if (cmd_q.command == CmdRead) begin
      res_d.slot_index = cmd_q.read_slot;
      res_d.pos_x      = sel_q.pos_x;
      res_d.pos_y      = sel_q.pos_y;
      res_d.brightness = sel_q.shade;
      res_d.alpha      = sel_q.alpha;
      res_d.life_left  = sel_q.life;
    end else if (cmd_q.command == CmdSpawn) begin
      res_d.slot_index = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      vld_q    <= '0;
      last_q   <= '0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
      live_q   <= '0;
      found_q  <= '0;
      sel_q    <= '0;
      pv_q     <= 1'b0;
      pl_q     <= 1'b0;
      pa_q     <= '0;
      rv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      live_q  <= live_d;
      found_q <= found_d;
      sel_q   <= sel_d;
      pv_q    <= issue;
      pl_q    <= issue && (cnt_q == IdxW'(PARTICLES - 1));
      if (issue) begin
        pa_q <= cur;
        rv_q <= vld_q[cur];
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (state_q == StSearch && we) begin
        last_q <= waddr;
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (issue) begin
      rd_q <= mem_q[cur];
    end
    if (state_q == StIdle && in_i.valid) begin
      cmd_q <= in_i.data;
    end
    new_q <= new_slot;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.data  = res_q;
endmodule

// ===== tb/tb_particle_pool_update.sv =====
`timescale 1ns / 100ps

module tb_particle_pool_update;
  import ppu_pkg::*;

  localparam int unsigned Slots = 64;
  localparam int unsigned RandomWords = 650;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppu_if #(.word_t(in_word_t))  cmd_if ();
  ppu_if #(.word_t(out_word_t)) res_if ();

  particle_pool_update #(.PARTICLES(Slots)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if.sink),
    .out_o (res_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [PosW-1:0] pool_pos_x [Slots];
  logic signed [PosW-1:0] pool_pos_y [Slots];
  logic signed [PosW-1:0] pool_vel_x [Slots];
  logic signed [PosW-1:0] pool_vel_y [Slots];
  logic [FracW-1:0]       pool_shade [Slots];
  logic [FracW-1:0]       pool_alpha [Slots];
  logic [FracW-1:0]       pool_life [Slots];
  int unsigned            pool_last;

  out_word_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned n_spawn = 0, n_tick = 0, n_read = 0, n_other = 0;
  int unsigned full_pool_spawns = 0;
  bit calm = 1'b0;

  function automatic logic signed [PosW-1:0] clamp_pos(longint x);
    if (x > 64'sd8388607) return PosMax;
    if (x < -64'sd8388608) return PosMin;
    return x[PosW-1:0];
  endfunction

  function automatic logic signed [PosW-1:0] tenth_rounded(logic signed [PosW-1:0] v);
    int s;
    s = v;
    return (s >= 0) ? PosW'((s + 5) / 10) : PosW'(-((-s + 5) / 10));
  endfunction

  function automatic longint drift_of(logic signed [PosW-1:0] vel, logic [DeltaW-1:0] d);
    longint p;
    p = longint'(vel) * longint'({1'b0, d}) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic int unsigned claim_slot();
    int unsigned i;
    for (i = pool_last; i < Slots; i++) begin
      if (pool_life[i] == '0) begin
        pool_last = i;
        return i;
      end
    end
    for (i = 0; i < pool_last; i++) begin
      if (pool_life[i] == '0) begin
        pool_last = i;
        return i;
      end
    end
    pool_last = 0;
    full_pool_spawns++;
    return 0;
  endfunction

  function automatic out_word_t pool_step(in_word_t w);
    out_word_t r;
    int jv, jit;
    int unsigned k, live, d, fade;
    r = '0;
    live = 0;
    case (w.command)
      CmdSpawn: begin
        n_spawn++;
        jv = (int'(w.jitter_random) - 50) * 256;
        jit = (jv >= 0) ? (jv + 5) / 10 : -((-jv + 5) / 10);
        k = claim_slot();
        pool_pos_x[k] = clamp_pos(longint'(w.ball_x) + longint'(w.spawn_offset_x) + jit);
        pool_pos_y[k] = clamp_pos(longint'(w.ball_y) + longint'(w.spawn_offset_y) + jit);
        pool_vel_x[k] = tenth_rounded(w.ball_vel_x);
        pool_vel_y[k] = tenth_rounded(w.ball_vel_y);
        pool_shade[k] = FracW'(32768 + (int'(w.shade_random) * 65536 + 50) / 100);
        pool_alpha[k] = OneQ16;
        pool_life[k] = OneQ16;
        r.slot_index = SlotW'(k);
      end
      CmdTick: begin
        n_tick++;
        d = w.delta_time;
        fade = (5 * d + 1) >> 1;
        for (int i = 0; i < Slots; i++) begin
          pool_life[i] = (pool_life[i] > d) ? FracW'(pool_life[i] - d) : '0;
          if (pool_life[i] != '0) begin
            pool_pos_x[i] = clamp_pos(longint'(pool_pos_x[i]) - drift_of(pool_vel_x[i], d));
            pool_pos_y[i] = clamp_pos(longint'(pool_pos_y[i]) - drift_of(pool_vel_y[i], d));
            pool_alpha[i] = (pool_alpha[i] > fade) ? FracW'(pool_alpha[i] - fade) : '0;
          end
        end
      end
      CmdRead: begin
        n_read++;
        k = w.read_slot;
        r.slot_index = w.read_slot;
        r.pos_x = pool_pos_x[k];
        r.pos_y = pool_pos_y[k];
        r.brightness = pool_shade[k];
        r.alpha = pool_alpha[k];
        r.life_left = pool_life[k];
      end
      default: n_other++;
    endcase
    for (int i = 0; i < Slots; i++) begin
      if (pool_life[i] != '0) live++;
    end
    r.live_count = CountW'(live);
    return r;
  endfunction

  task automatic report_field(string name, longint e, longint a, ref bit bad);
    if (e != a) begin
      bad = 1'b1;
      if (mismatches < 10) begin
        $display("Mismatch on word %0d, %s: expected %0d, got %0d", words_checked, name, e, a);
      end
    end
  endtask

  function automatic in_word_t blank_word(logic [CmdW-1:0] c);
    in_word_t w;
    w = '0;
    w.command = c;
    return w;
  endfunction

  function automatic logic signed [PosW-1:0] any_pos();
    if ($urandom_range(1, 0) == 0) return PosW'($urandom);
    return PosW'($signed($urandom_range(8192, 0)) - 4096);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int unsigned pick;
    w = '0;
    w.ball_x = any_pos();
    w.ball_y = any_pos();
    w.ball_vel_x = PosW'($urandom);
    w.ball_vel_y = any_pos();
    w.spawn_offset_x = any_pos();
    w.spawn_offset_y = any_pos();
    w.jitter_random = ($urandom_range(9, 0) == 0) ? RandW'($urandom)
                                                  : RandW'($urandom_range(99, 0));
    w.shade_random = ($urandom_range(9, 0) == 0) ? RandW'($urandom)
                                                 : RandW'($urandom_range(99, 0));
    w.delta_time = ($urandom_range(19, 0) == 0) ? DeltaW'($urandom)
                                                : DeltaW'($urandom_range(1500, 0));
    w.read_slot = SlotW'($urandom_range(Slots - 1, 0));
    pick = $urandom_range(99, 0);
    if (pick < 42) w.command = CmdSpawn;
    else if (pick < 64) w.command = CmdTick;
    else if (pick < 95) w.command = CmdRead;
    else w.command = CmdUnknown;
    return w;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_result);
    int unsigned gap;
    out_word_t predicted;
    gap = calm ? 0 : $urandom_range(11, 0);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= w;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    predicted = pool_step(w);
    pending_results = {pending_results, (typed ? typed_result : predicted)};
  endtask

  always begin
    int unsigned stall;
    out_word_t e, a;
    bit bad;
    if (!rst_ni) begin
      @(posedge clk_i);
    end else begin
      stall = calm ? 0 : $urandom_range(11, 0);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      a = res_if.data;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word with slot %0d", a.slot_index);
      end else begin
        e = pending_results.pop_front();
        bad = 1'b0;
        report_field("slot_index", e.slot_index, a.slot_index, bad);
        report_field("pos_x", e.pos_x, a.pos_x, bad);
        report_field("pos_y", e.pos_y, a.pos_y, bad);
        report_field("brightness", e.brightness, a.brightness, bad);
        report_field("alpha", e.alpha, a.alpha, bad);
        report_field("life_left", e.life_left, a.life_left, bad);
        report_field("live_count", e.live_count, a.live_count, bad);
        if (bad) mismatches++;
      end
      words_checked++;
    end
  end

  initial begin
    row_t rows[$];
    row_t row;
    in_word_t w;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      pool_pos_x[i] = '0;
      pool_pos_y[i] = '0;
      pool_vel_x[i] = '0;
      pool_vel_y[i] = '0;
      pool_shade[i] = '0;
      pool_alpha[i] = '0;
      pool_life[i] = '0;
    end
    pool_last = 0;

    row = '{blank_word(CmdRead), 1'b1, '0};
    rows = {rows, row};
    w = blank_word(CmdTick);
    w.delta_time = 16'd100;
    row = '{w, 1'b1, '0};
    rows = {rows, row};
    row = '{blank_word(CmdUnknown), 1'b1, '0};
    rows = {rows, row};
    w = blank_word(CmdRead);
    w.read_slot = 6'd63;
    row = '{w, 1'b1, '0};
    row.result.slot_index = 6'd63;
    rows = {rows, row};
    w = blank_word(CmdSpawn);
    w.ball_x = PosMax;
    w.ball_y = PosMax;
    w.spawn_offset_x = PosMax;
    w.spawn_offset_y = PosMax;
    w.ball_vel_x = PosMax;
    w.ball_vel_y = 24'sd15;
    w.jitter_random = 7'd99;
    w.shade_random = 7'd99;
    row = '{w, 1'b1, '0};
    row.result.live_count = 7'd1;
    rows = {rows, row};
    w = blank_word(CmdSpawn);
    w.ball_x = PosMin;
    w.ball_y = PosMin;
    w.spawn_offset_x = PosMin;
    w.spawn_offset_y = PosMin;
    w.ball_vel_x = PosMin;
    w.ball_vel_y = -24'sd15;
    row = '{w, 1'b1, '0};
    row.result.slot_index = 6'd1;
    row.result.live_count = 7'd2;
    rows = {rows, row};
    w = blank_word(CmdRead);
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w.read_slot = 6'd1;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdSpawn);
    w.jitter_random = 7'd127;
    w.shade_random = 7'd127;
    w.ball_vel_x = -24'sd25;
    w.ball_vel_y = 24'sd25;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdRead);
    w.read_slot = 6'd2;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdTick);
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w.delta_time = 16'd20000;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdRead);
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w.read_slot = 6'd2;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdTick);
    w.delta_time = 16'hFFFF;
    row = '{w, 1'b1, '0};
    rows = {rows, row};
    w = blank_word(CmdRead);
    w.read_slot = 6'd1;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdSpawn);
    w.ball_x = 24'sd1000;
    w.jitter_random = 7'd50;
    w.shade_random = 7'd50;
    row = '{w, 1'b0, '0};
    rows = {rows, row};
    w = blank_word(CmdRead);
    w.read_slot = 6'd2;
    row = '{w, 1'b0, '0};
    rows = {rows, row};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].result);
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(2, 0) == 0);
      send_word(random_word(), 1'b0, '0);
    end
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Checked %0d result words: %0d spawns, %0d ticks, %0d reads, %0d unknown.",
             words_checked, n_spawn, n_tick, n_read, n_other);
    $display("Spawns into a full pool: %0d; mismatching words: %0d.",
             full_pool_spawns, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== particle_pool_update.f =====
design/ppu_pkg.sv
design/ppu_if.sv
design/ppu_slot_alu.sv
design/particle_pool_update.sv
tb/tb_particle_pool_update.sv
